FILE: hw/rtl/amo64_pkg.sv
// amo64_pkg: shared types and constants of the 64-bit atomic memory operation unit
// holds request codes, decoded operation kinds, queue entry layout and sizes
// no dependencies
package amo64_pkg;

    // word store size and index width
    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // field widths
    localparam int TYPE_W  = 4;
    localparam int INDEX_W = 10;
    localparam int WORD_W  = 64;

    // stream data widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_DATA_BITS = INDEX_W + 2 * WORD_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int S_PAD_W     = S_DATA_W - S_DATA_BITS;
    localparam int M_DATA_W    = WORD_W;

    // request type codes on the input stream
    localparam logic [TYPE_W-1:0] REQ_LOAD     = 4'd0;
    localparam logic [TYPE_W-1:0] REQ_STORE    = 4'd1;
    localparam logic [TYPE_W-1:0] REQ_EXCHANGE = 4'd2;
    localparam logic [TYPE_W-1:0] REQ_CAS      = 4'd3;
    localparam logic [TYPE_W-1:0] REQ_ADD      = 4'd4;
    localparam logic [TYPE_W-1:0] REQ_SUB      = 4'd5;
    localparam logic [TYPE_W-1:0] REQ_AND      = 4'd6;
    localparam logic [TYPE_W-1:0] REQ_OR       = 4'd7;
    localparam logic [TYPE_W-1:0] REQ_XOR      = 4'd8;
    localparam logic [TYPE_W-1:0] REQ_NAND     = 4'd9;

    // decoded operation kind carried to the execution side
    typedef enum logic [3:0] {
        OP_LOAD     = 4'd0,
        OP_STORE    = 4'd1,
        OP_EXCHANGE = 4'd2,
        OP_CAS      = 4'd3,
        OP_ADD      = 4'd4,
        OP_SUB      = 4'd5,
        OP_AND      = 4'd6,
        OP_OR       = 4'd7,
        OP_XOR      = 4'd8,
        OP_NAND     = 4'd9
    } op_t;

    // one classified request as it waits in the queue
    typedef struct packed {
        op_t                op;
        logic [MEM_AW-1:0]  idx;
        logic [WORD_W-1:0]  operand;
        logic [WORD_W-1:0]  expected;
    } req_t;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: hw/rtl/amo64_front.sv
// amo64_front: input side of the atomic unit, accepts request beats and classifies them
// depends on amo64_pkg
module amo64_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: word_index, operand_value, expected_value, zero pad
    input  logic [amo64_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: req_type
    input  logic [amo64_pkg::TYPE_W-1:0]        s_tuser,
    input  amo64_pkg::q_status_t                q_status,
    output logic                                q_push,
    output amo64_pkg::req_t                     q_entry
);

    logic [amo64_pkg::INDEX_W-1:0] word_index;
    logic [amo64_pkg::WORD_W-1:0]  operand_value;
    logic [amo64_pkg::WORD_W-1:0]  expected_value;
    amo64_pkg::op_t                op;

    // unpack the beat
    assign word_index     = s_tdata[amo64_pkg::INDEX_W-1:0];
    assign operand_value  = s_tdata[amo64_pkg::INDEX_W +: amo64_pkg::WORD_W];
    assign expected_value = s_tdata[amo64_pkg::INDEX_W + amo64_pkg::WORD_W +: amo64_pkg::WORD_W];

    // classify the request, unknown codes behave as a load
    always_comb begin
        unique case (s_tuser) inside
            [amo64_pkg::REQ_LOAD:amo64_pkg::REQ_NAND]: op = amo64_pkg::op_t'(s_tuser);
            default: op = amo64_pkg::OP_LOAD;
        endcase
    end

    // accept whenever the queue has room
    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && s_tready;

    // word index wraps to the store size
    assign q_entry.op       = op;
    assign q_entry.idx      = word_index[amo64_pkg::MEM_AW-1:0];
    assign q_entry.operand  = operand_value;
    assign q_entry.expected = expected_value;

endmodule

FILE: hw/rtl/amo64_queue.sv
// amo64_queue: short request queue between the front and back of the atomic unit
// depends on amo64_pkg
module amo64_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  amo64_pkg::req_t         push_entry,
    output amo64_pkg::q_status_t    status,
    input  logic                    pop,
    output amo64_pkg::req_t         head
);

    amo64_pkg::req_t                slot_reg [amo64_pkg::Q_DEPTH];
    logic [amo64_pkg::Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [amo64_pkg::Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [amo64_pkg::Q_CW-1:0]     count_reg, count_next;
    logic                           do_push, do_pop;

    assign status.full  = (count_reg == amo64_pkg::Q_CW'(amo64_pkg::Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == amo64_pkg::Q_AW'(amo64_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + amo64_pkg::Q_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == amo64_pkg::Q_AW'(amo64_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + amo64_pkg::Q_AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + amo64_pkg::Q_CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - amo64_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    // fill count never goes past the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= amo64_pkg::Q_CW'(amo64_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    // count rises by one on a push without a pop
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + amo64_pkg::Q_CW'(1))
        else $error("queue count missed a push");

    // pointers agree when the queue is empty or full
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.empty || status.full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");
`endif

endmodule

FILE: hw/rtl/amo64_back.sv
// amo64_back: execution side of the atomic unit, word store, read-modify-write and result register
// depends on amo64_pkg
module amo64_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  amo64_pkg::q_status_t            q_status,
    input  amo64_pkg::req_t                 q_head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: old_word
    output logic [amo64_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: success
    output logic [0:0]                      m_tuser
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic [amo64_pkg::WORD_W-1:0]   mem [amo64_pkg::MEM_WORDS];
    logic                           state_reg, state_next;
    amo64_pkg::req_t                req_reg;
    logic [amo64_pkg::WORD_W-1:0]   rd_data_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [amo64_pkg::WORD_W-1:0]   out_word_reg;
    logic                           out_ok_reg;
    logic                           start;
    logic                           slot_free;
    logic [amo64_pkg::MEM_AW-1:0]   mem_addr;
    logic                           mem_we;
    logic [amo64_pkg::WORD_W-1:0]   new_word;
    logic                           ok;

    // output slot is free now or is taken this cycle
    assign slot_free = !out_valid_reg || m_tready;
    assign start     = (state_reg == ST_IDLE) && !q_status.empty && slot_free;
    assign q_pop     = start;

    // single port: read in idle, write back in exec
    assign mem_addr  = (state_reg == ST_EXEC) ? req_reg.idx : q_head.idx;
    assign mem_we    = (state_reg == ST_EXEC);

    // new word and cas outcome from the old word
    always_comb begin
        ok       = 1'b1;
        new_word = rd_data_reg;
        unique case (req_reg.op)
            amo64_pkg::OP_LOAD:     new_word = rd_data_reg;
            amo64_pkg::OP_STORE:    new_word = req_reg.operand;
            amo64_pkg::OP_EXCHANGE: new_word = req_reg.operand;
            amo64_pkg::OP_CAS: begin
                if (rd_data_reg == req_reg.expected) begin
                    new_word = req_reg.operand;
                end else begin
                    ok = 1'b0;
                end
            end
            amo64_pkg::OP_ADD:      new_word = rd_data_reg + req_reg.operand;
            amo64_pkg::OP_SUB:      new_word = rd_data_reg - req_reg.operand;
            amo64_pkg::OP_AND:      new_word = rd_data_reg & req_reg.operand;
            amo64_pkg::OP_OR:       new_word = rd_data_reg | req_reg.operand;
            amo64_pkg::OP_XOR:      new_word = rd_data_reg ^ req_reg.operand;
            amo64_pkg::OP_NAND:     new_word = ~(rd_data_reg & req_reg.operand);
            default:                new_word = rd_data_reg;
        endcase
    end

    // sequencer: idle issues the read, exec writes back and loads the result
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // result slot valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_EXEC) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request latch and result payload
    always_ff @(posedge aclk) begin
        if (start) begin
            req_reg <= q_head;
        end
        if (state_reg == ST_EXEC) begin
            out_word_reg <= rd_data_reg;
            out_ok_reg   <= ok;
        end
    end

    // word store, one access per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= new_word;
        end
        if (start) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_word_reg;
    assign m_tuser[0] = out_ok_reg;

`ifndef NO_ASSERTIONS
    // a write-back always follows a read and then returns to idle
    a_exec_one: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |=> state_reg == ST_IDLE)
        else $error("exec lasted more than one cycle");

    // a read is only issued when the result slot will be free at write-back
    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !out_valid_reg)
        else $error("result slot busy at write-back");

    // only compare-and-swap can report failure
    a_ok_cas: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && req_reg.op != amo64_pkg::OP_CAS) |-> ok)
        else $error("failure reported for a non-cas request");

    // the queue is never popped during write-back
    a_no_pop_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |-> !q_pop)
        else $error("queue popped during write-back");
`endif

endmodule

FILE: hw/rtl/atomic_memory_op_unit_64_core.sv
// atomic_memory_op_unit_64_core: a request beat passes the queue, request latch and read data
// register, then the result register; the single-port word store (read, then write) ends
// a request before the next; a 2-entry queue takes beats while a result waits on m_tready
// aresetn is synchronous and active low; it clears control state only
// the word store has no reset and holds undefined data until a word is written
// depends on amo64_pkg, amo64_front, amo64_queue, amo64_back
module atomic_memory_op_unit_64_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: word_index [9:0], operand_value [73:10], expected_value [137:74], zero pad
    input  logic [amo64_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: req_type [3:0]
    input  logic [amo64_pkg::TYPE_W-1:0]        s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: old_word [63:0]
    output logic [amo64_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: success [0]
    output logic [0:0]                          m_tuser
);

    amo64_pkg::q_status_t   q_status;
    amo64_pkg::req_t        q_entry;
    amo64_pkg::req_t        q_head;
    logic                   q_push;
    logic                   q_pop;

    // accept and classify
    amo64_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decoupling queue
    amo64_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .status     (q_status),
        .pop        (q_pop),
        .head       (q_head)
    );

    // execute against the word store
    amo64_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
